FILE: src/segment_rectangle_intersect_macros.svh
// assertion macros shared by the segment/rectangle intersection pipeline
// no dependencies; included by files that carry concurrent assertions
`ifndef SEGMENT_RECTANGLE_INTERSECT_MACROS_SVH
`define SEGMENT_RECTANGLE_INTERSECT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define SRI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define SRI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sri_pkg.sv
// shared constants and types for the segment/rectangle intersection pipeline
// no dependencies
package sri_pkg;

  // default coordinate width (signed q12.4)
  localparam int COORD_BITS_DEF = 16;

  // per-item decisions that bypass the cross-product test
  typedef struct packed {
    logic miss;  // clipped x-span empty or rectangle inverted in y
    logic vert;  // segment has zero x extent
    logic vhit;  // y-span overlap result for the zero x extent case
  } sri_flags_t;

endpackage

FILE: src/sri_in_if.sv
// input channel: rectangle corners and segment endpoints with valid/ready
// depends on nothing
interface sri_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rect_min_x;
  logic signed [COORD_BITS-1:0] rect_min_y;
  logic signed [COORD_BITS-1:0] rect_max_x;
  logic signed [COORD_BITS-1:0] rect_max_y;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
           start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
           start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

FILE: src/sri_out_if.sv
// result channel: one hit bit per item with valid/ready
// depends on nothing
interface sri_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

FILE: src/sri_front.sv
// first two pipeline stages: x-span clipping, direction normalize, offsets
// depends on sri_pkg and segment_rectangle_intersect_macros.svh
`include "segment_rectangle_intersect_macros.svh"

module sri_front #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] rect_min_x,
  input  logic signed [COORD_BITS-1:0] rect_min_y,
  input  logic signed [COORD_BITS-1:0] rect_max_x,
  input  logic signed [COORD_BITS-1:0] rect_max_y,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS:0]   dlo,
  output logic signed [COORD_BITS:0]   dhi,
  output logic signed [COORD_BITS:0]   etop,
  output logic signed [COORD_BITS:0]   ebot,
  output logic signed [COORD_BITS:0]   dx,
  output logic signed [COORD_BITS:0]   dy,
  output sri_pkg::sri_flags_t          flags
);

  localparam int DW = COORD_BITS + 1;

  // stage 1
  logic                         v1_r;
  logic signed [COORD_BITS-1:0] lo1_r, hi1_r, ylo1_r, yhi1_r;
  logic signed [COORD_BITS-1:0] x1_1_r, y1_1_r, ry0_1_r, ry1_1_r;
  logic signed [DW-1:0]         dx1_r, dy1_r;
  logic                         vert1_r;

  logic signed [COORD_BITS-1:0] xmin, xmax;
  logic signed [COORD_BITS-1:0] lo1_nxt, hi1_nxt, ylo1_nxt, yhi1_nxt;
  logic signed [DW-1:0]         dxr, dyr, dx1_nxt, dy1_nxt;

  // stage 2
  logic                         v2_r;
  logic signed [DW-1:0]         dlo2_r, dhi2_r, etop2_r, ebot2_r, dx2_r, dy2_r;
  sri_pkg::sri_flags_t          flags2_r;

  logic                         rdy1, rdy2;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    xmin     = (start_x < end_x) ? start_x : end_x;
    xmax     = (start_x < end_x) ? end_x : start_x;
    lo1_nxt  = (xmin < rect_min_x) ? rect_min_x : xmin;
    hi1_nxt  = (xmax > rect_max_x) ? rect_max_x : xmax;
    ylo1_nxt = (start_y < end_y) ? start_y : end_y;
    yhi1_nxt = (start_y < end_y) ? end_y : start_y;
    dxr      = DW'(end_x) - DW'(start_x);
    dyr      = DW'(end_y) - DW'(start_y);
    // make dx non-negative, flip dy along with it
    dx1_nxt  = dxr[DW-1] ? -dxr : dxr;
    dy1_nxt  = dxr[DW-1] ? -dyr : dyr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      lo1_r   <= lo1_nxt;
      hi1_r   <= hi1_nxt;
      ylo1_r  <= ylo1_nxt;
      yhi1_r  <= yhi1_nxt;
      x1_1_r  <= start_x;
      y1_1_r  <= start_y;
      ry0_1_r <= rect_min_y;
      ry1_1_r <= rect_max_y;
      dx1_r   <= dx1_nxt;
      dy1_r   <= dy1_nxt;
      vert1_r <= (start_x == end_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      dlo2_r        <= DW'(lo1_r) - DW'(x1_1_r);
      dhi2_r        <= DW'(hi1_r) - DW'(x1_1_r);
      etop2_r       <= DW'(y1_1_r) - DW'(ry1_1_r);
      ebot2_r       <= DW'(y1_1_r) - DW'(ry0_1_r);
      dx2_r         <= dx1_r;
      dy2_r         <= dy1_r;
      flags2_r.miss <= (lo1_r > hi1_r) || (ry0_1_r > ry1_1_r);
      flags2_r.vert <= vert1_r;
      flags2_r.vhit <= (ylo1_r <= ry1_1_r) && (yhi1_r >= ry0_1_r);
    end
  end

  assign out_valid = v2_r;
  assign dlo       = dlo2_r;
  assign dhi       = dhi2_r;
  assign etop      = etop2_r;
  assign ebot      = ebot2_r;
  assign dx        = dx2_r;
  assign dy        = dy2_r;
  assign flags     = flags2_r;

  `SRI_ASSERT_IMP(a_clip_order, clk, rst_n, v2_r && !flags2_r.miss, dlo2_r <= dhi2_r,
    "clipped span inverted without miss flag")
  `SRI_ASSERT_IMP(a_dx_positive, clk, rst_n, v2_r && !flags2_r.vert,
    !dx2_r[DW-1] && (dx2_r != '0), "dx not positive for sloped segment")

endmodule

FILE: src/sri_mul.sv
// third pipeline stage: the four cross-product terms
// depends on sri_pkg
module sri_mul #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS:0]    dlo,
  input  logic signed [COORD_BITS:0]    dhi,
  input  logic signed [COORD_BITS:0]    etop,
  input  logic signed [COORD_BITS:0]    ebot,
  input  logic signed [COORD_BITS:0]    dx,
  input  logic signed [COORD_BITS:0]    dy,
  input  sri_pkg::sri_flags_t           in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [2*COORD_BITS+1:0] pa,
  output logic signed [2*COORD_BITS+1:0] pb,
  output logic signed [2*COORD_BITS+1:0] pc,
  output logic signed [2*COORD_BITS+1:0] pd,
  output sri_pkg::sri_flags_t           out_flags
);

  localparam int PW = 2 * COORD_BITS + 2;

  logic                 v_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [PW-1:0] pa_nxt, pb_nxt, pc_nxt, pd_nxt;
  sri_pkg::sri_flags_t  flags_r;

  assign in_ready = !v_r || out_ready;

  // products fit exactly in PW bits
  always_comb begin
    pa_nxt = PW'(dy) * PW'(dlo);
    pb_nxt = PW'(dy) * PW'(dhi);
    pc_nxt = PW'(etop) * PW'(dx);
    pd_nxt = PW'(ebot) * PW'(dx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      pc_r    <= pc_nxt;
      pd_r    <= pd_nxt;
      flags_r <= in_flags;
    end
  end

  assign out_valid = v_r;
  assign pa        = pa_r;
  assign pb        = pb_r;
  assign pc        = pc_r;
  assign pd        = pd_r;
  assign out_flags = flags_r;

endmodule

FILE: src/sri_cmp.sv
// last pipeline stage: cross-product signs, final decision, output register
// depends on sri_pkg and segment_rectangle_intersect_macros.svh
`include "segment_rectangle_intersect_macros.svh"

module sri_cmp #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [2*COORD_BITS+1:0] pa,
  input  logic signed [2*COORD_BITS+1:0] pb,
  input  logic signed [2*COORD_BITS+1:0] pc,
  input  logic signed [2*COORD_BITS+1:0] pd,
  input  sri_pkg::sri_flags_t            in_flags,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit
);

  localparam int SW = 2 * COORD_BITS + 3;

  logic                 v_r;
  logic                 hit_r;
  logic                 hit_nxt;
  logic signed [SW-1:0] s_lo_top, s_hi_top, s_lo_bot, s_hi_bot;
  logic                 below_top, above_bot;

  assign in_ready = !v_r || out_ready;

  // line y at clipped x versus the y bounds, scaled by dx
  always_comb begin
    s_lo_top  = SW'(pa) + SW'(pc);
    s_hi_top  = SW'(pb) + SW'(pc);
    s_lo_bot  = SW'(pa) + SW'(pd);
    s_hi_bot  = SW'(pb) + SW'(pd);
    below_top = s_lo_top[SW-1] || (s_lo_top == '0) ||
                s_hi_top[SW-1] || (s_hi_top == '0);
    above_bot = !s_lo_bot[SW-1] || !s_hi_bot[SW-1];
    if (in_flags.miss) begin
      hit_nxt = 1'b0;
    end else if (in_flags.vert) begin
      hit_nxt = in_flags.vhit;
    end else begin
      hit_nxt = below_top && above_bot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_valid = v_r;
  assign hit       = hit_r;

  `SRI_ASSERT_NXT(a_miss_clears_hit, clk, rst_n, in_valid && in_ready && in_flags.miss,
    v_r && !hit_r, "missed item produced a hit")
  `SRI_ASSERT_NXT(a_vert_passes_vhit, clk, rst_n,
    in_valid && in_ready && !in_flags.miss && in_flags.vert,
    v_r && (hit_r == $past(in_flags.vhit)), "vertical segment result not taken from y overlap")

endmodule

FILE: src/segment_rectangle_intersect.sv
// segment versus axis-aligned rectangle hit test, four-stage pipeline
// depends on sri_pkg, sri_in_if, sri_out_if, sri_front, sri_mul, sri_cmp
//
// usage
//   in_ch  : one transfer carries a rectangle (min/max corners) and a segment
//            (two endpoints), all signed q12.4, COORD_BITS wide
//   out_ch : one transfer per input item carries hit, 1 when the segment
//            touches or crosses the rectangle, edges included
//   results leave in the order the items came in
// pipeline: one register stage each for clipping, offsets, products and
//   the sign test
// throughput: one item per cycle while out_ch.ready stays high, set by the
//   single multiplier stage that forms all four cross products in parallel
// stall: when out_ch.ready is low the output holds; upstream stages keep
//   filling empty slots, so in_ch.ready drops only once all four stages
//   hold items; nothing is dropped or repeated
// reset: synchronous, active low rst_n clears every stage valid bit, so no
//   result is shown until new items are taken
module segment_rectangle_intersect #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sri_in_if.sink    in_ch,
  sri_out_if.source out_ch
);

  // front -> multiplier stage
  logic                           fm_valid, fm_ready;
  logic signed [COORD_BITS:0]     fm_dlo, fm_dhi, fm_etop, fm_ebot, fm_dx, fm_dy;
  sri_pkg::sri_flags_t            fm_flags;

  // multiplier -> compare stage
  logic                           mc_valid, mc_ready;
  logic signed [2*COORD_BITS+1:0] mc_pa, mc_pb, mc_pc, mc_pd;
  sri_pkg::sri_flags_t            mc_flags;

  // clip x-span, normalize direction, form offsets from the first endpoint
  sri_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .rect_min_x (in_ch.rect_min_x),
    .rect_min_y (in_ch.rect_min_y),
    .rect_max_x (in_ch.rect_max_x),
    .rect_max_y (in_ch.rect_max_y),
    .start_x    (in_ch.start_x),
    .start_y    (in_ch.start_y),
    .end_x      (in_ch.end_x),
    .end_y      (in_ch.end_y),
    .out_valid  (fm_valid),
    .out_ready  (fm_ready),
    .dlo        (fm_dlo),
    .dhi        (fm_dhi),
    .etop       (fm_etop),
    .ebot       (fm_ebot),
    .dx         (fm_dx),
    .dy         (fm_dy),
    .flags      (fm_flags)
  );

  // dy*(x-x1) at both clipped ends and (y1-yb)*dx for both y bounds
  sri_mul #(
    .COORD_BITS (COORD_BITS)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fm_valid),
    .in_ready  (fm_ready),
    .dlo       (fm_dlo),
    .dhi       (fm_dhi),
    .etop      (fm_etop),
    .ebot      (fm_ebot),
    .dx        (fm_dx),
    .dy        (fm_dy),
    .in_flags  (fm_flags),
    .out_valid (mc_valid),
    .out_ready (mc_ready),
    .pa        (mc_pa),
    .pb        (mc_pb),
    .pc        (mc_pc),
    .pd        (mc_pd),
    .out_flags (mc_flags)
  );

  // exact sign tests and final hit, drives the output register
  sri_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mc_valid),
    .in_ready  (mc_ready),
    .pa        (mc_pa),
    .pb        (mc_pb),
    .pc        (mc_pc),
    .pd        (mc_pd),
    .in_flags  (mc_flags),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .hit       (out_ch.hit)
  );

endmodule

FILE: test/segment_rectangle_intersect_tb.sv
// testbench for segment_rectangle_intersect: directed and random segment/rectangle queries
// depends on sri_pkg, sri_in_if, sri_out_if and the segment_rectangle_intersect pipeline
`timescale 1ns / 1ps

module segment_rectangle_intersect_tb;

  localparam int CB          = sri_pkg::COORD_BITS_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int STALL_LIMIT = 5000;   // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 60;     // receiver hold-off, well past the pipeline depth
  localparam int TAIL_CYCLES = 8;      // tail wait after the final drain

  // one query as it crosses the input channel
  typedef struct packed {
    logic signed [CB-1:0] rect_min_x;
    logic signed [CB-1:0] rect_min_y;
    logic signed [CB-1:0] rect_max_x;
    logic signed [CB-1:0] rect_max_y;
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;
  } seg_query_t;

  // predicts the hit bit of each accepted query and checks results in order
  class hit_tracker;
    bit expected_hits[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // sign source of (y(x) - yb) scaled by dx > 0, exact in 64 bits
    function longint line_side(longint x1, y1, dx, dy, x, yb);
      return dy * (x - x1) + (y1 - yb) * dx;
    endfunction

    function bit predict_hit(seg_query_t q);
      longint rx0, ry0, rx1, ry1, x1, y1, x2, y2;
      longint lo, hi, dx, dy, ylo, yhi;
      bit below_top, above_bot;
      rx0 = q.rect_min_x;
      ry0 = q.rect_min_y;
      rx1 = q.rect_max_x;
      ry1 = q.rect_max_y;
      x1  = q.start_x;
      y1  = q.start_y;
      x2  = q.end_x;
      y2  = q.end_y;
      // clip the segment's x-span to the rectangle's x-span
      lo = (x1 < x2) ? x1 : x2;
      hi = (x1 < x2) ? x2 : x1;
      if (hi > rx1) hi = rx1;
      if (lo < rx0) lo = rx0;
      if (lo > hi || ry0 > ry1) return 1'b0;
      // zero x extent: plain interval overlap of the endpoint ys
      if (x1 == x2) begin
        ylo = (y1 < y2) ? y1 : y2;
        yhi = (y1 < y2) ? y2 : y1;
        return (ylo <= ry1) && (yhi >= ry0);
      end
      dx = x2 - x1;
      dy = y2 - y1;
      if (dx < 0) begin
        dx = -dx;
        dy = -dy;
      end
      below_top = line_side(x1, y1, dx, dy, lo, ry1) <= 0 ||
                  line_side(x1, y1, dx, dy, hi, ry1) <= 0;
      above_bot = line_side(x1, y1, dx, dy, lo, ry0) >= 0 ||
                  line_side(x1, y1, dx, dy, hi, ry0) >= 0;
      return below_top && above_bot;
    endfunction

    function void note_query(seg_query_t q);
      expected_hits.push_back(predict_hit(q));
    endfunction

    function void check_hit(bit actual);
      bit want;
      if (expected_hits.size() == 0) begin
        $display("%0t: result hit=%0b with no query outstanding", $time, actual);
        errors++;
      end else begin
        want = expected_hits.pop_front();
        if (want != actual) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sri_in_if #(.COORD_BITS(CB)) in_ch ();
  sri_out_if                   out_ch ();

  segment_rectangle_intersect #(.COORD_BITS(CB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hit_tracker sb;
  seg_query_t seen_query;
  int         idle_cycles;
  bit         tx_steady;   // sender never idles while set
  bit         rx_steady;   // receiver never idles while set
  bit         hold_rx;     // one-shot request for a long receiver hold-off

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // monitor: both channels sampled at the rising edge, watchdog on transfer activity
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_query = '{in_ch.rect_min_x, in_ch.rect_min_y, in_ch.rect_max_x,
                     in_ch.rect_max_y, in_ch.start_x, in_ch.start_y,
                     in_ch.end_x, in_ch.end_y};
      sb.note_query(seen_query);
    end
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_hit(out_ch.hit);

    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: ready changes only at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        // long hold-off so the four stages fill and in_ch.ready drops
        hold_rx      = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready = rx_steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // one query offered until the block takes it
  task automatic send_query(input seg_query_t q);
    @(negedge clk);
    if (!tx_steady && $urandom_range(99) < 4) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.rect_min_x = q.rect_min_x;
    in_ch.rect_min_y = q.rect_min_y;
    in_ch.rect_max_x = q.rect_max_x;
    in_ch.rect_max_y = q.rect_max_y;
    in_ch.start_x    = q.start_x;
    in_ch.start_y    = q.start_y;
    in_ch.end_x      = q.end_x;
    in_ch.end_y      = q.end_y;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic seg_query_t make_query(int rx0, int ry0, int rx1, int ry1,
                                            int x1, int y1, int x2, int y2);
    seg_query_t q;
    q.rect_min_x = rx0[CB-1:0];
    q.rect_min_y = ry0[CB-1:0];
    q.rect_max_x = rx1[CB-1:0];
    q.rect_max_y = ry1[CB-1:0];
    q.start_x    = x1[CB-1:0];
    q.start_y    = y1[CB-1:0];
    q.end_x      = x2[CB-1:0];
    q.end_y      = y2[CB-1:0];
    return q;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // value close to one end of the coordinate range
  function automatic int near_edge();
    return $urandom_range(1) ? pick(32700, 32767) : pick(-32768, -32700);
  endfunction

  function automatic seg_query_t random_query();
    seg_query_t q;
    int mode, rx0, ry0, x1, y1, y2;
    mode = $urandom_range(99);
    if (mode < 15) begin
      // raw bit patterns over the whole range
      q = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else if (mode < 70) begin
      // small scene so hits and misses both show up; width may go negative
      rx0 = pick(-48, 48);
      ry0 = pick(-48, 48);
      q = make_query(rx0, ry0, rx0 + pick(-4, 40), ry0 + pick(-4, 40),
                     pick(-80, 80), pick(-80, 80), pick(-80, 80), pick(-80, 80));
    end else if (mode < 85) begin
      // zero x extent, a third of them collapsed to a point
      rx0 = pick(-48, 48);
      ry0 = pick(-48, 48);
      x1  = pick(-80, 80);
      y1  = pick(-80, 80);
      y2  = ($urandom_range(2) == 0) ? y1 : pick(-80, 80);
      q = make_query(rx0, ry0, rx0 + pick(-4, 40), ry0 + pick(-4, 40), x1, y1, x1, y2);
    end else begin
      // products at their largest magnitude
      q = make_query(near_edge(), near_edge(), near_edge(), near_edge(),
                     near_edge(), near_edge(), near_edge(), near_edge());
    end
    return q;
  endfunction

  seg_query_t directed[$];

  initial begin
    sb          = new();
    idle_cycles = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    hold_rx     = 1'b0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.rect_min_x, in_ch.rect_min_y, in_ch.rect_max_x, in_ch.rect_max_y,
     in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y} = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: range extremes
    directed.push_back(make_query(-32768, -32768, 32767, 32767,
                                  -32768, -32768, 32767, 32767));
    directed.push_back(make_query(-32768, -32768, 32767, 32767,
                                  32767, -32768, -32768, 32767));
    directed.push_back(make_query(32767, 32767, 32767, 32767,
                                  -32768, -32768, 32767, 32767));
    directed.push_back(make_query(-32768, -32768, -32768, -32768,
                                  -32768, 32767, 32767, -32768));
    directed.push_back(make_query(32767, 32767, -32768, -32768,
                                  0, 0, 1, 1));
    // segment crossing, inside, outside, reversed direction
    directed.push_back(make_query(0, 0, 160, 160, -32, 80, 200, 80));
    directed.push_back(make_query(0, 0, 160, 160, 20, 30, 40, 50));
    directed.push_back(make_query(0, 0, 160, 160, 200, 0, 300, 160));
    directed.push_back(make_query(0, 0, 160, 160, 200, 80, -32, 80));
    directed.push_back(make_query(0, 0, 160, 160, -50, 200, 200, -50));
    // vertical segment: inside, above, touching top edge, spanning
    directed.push_back(make_query(0, 0, 10, 10, 5, 2, 5, 8));
    directed.push_back(make_query(0, 0, 10, 10, 5, 11, 5, 20));
    directed.push_back(make_query(0, 0, 10, 10, 10, 10, 10, 20));
    directed.push_back(make_query(0, 0, 10, 10, 3, 30, 3, -30));
    // inverted rectangle on x, then on y
    directed.push_back(make_query(10, 0, 0, 10, 5, 5, 6, 6));
    directed.push_back(make_query(0, 10, 10, 0, 5, 5, 6, 6));
    // degenerate segment: point inside, on a corner, outside
    directed.push_back(make_query(0, 0, 10, 10, 4, 4, 4, 4));
    directed.push_back(make_query(0, 0, 10, 10, 10, 0, 10, 0));
    directed.push_back(make_query(0, 0, 10, 10, 11, 4, 11, 4));
    // line y between lattice points: just above the top edge, then just touching
    directed.push_back(make_query(0, 0, 10, 10, -1, 10, 2, 11));
    directed.push_back(make_query(0, 0, 10, 10, -2, 11, 1, 10));
    directed.push_back(make_query(0, 0, 10, 10, -1, 0, 2, -1));
    // zero-size rectangle hit by a diagonal, and missed by one
    directed.push_back(make_query(3, 3, 3, 3, 0, 0, 6, 6));
    directed.push_back(make_query(3, 3, 3, 3, 0, 0, 6, 7));
    foreach (directed[i]) send_query(directed[i]);
    drain_results();

    // random: a steady stretch first, then idling, hold-off and a full pause
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_steady = (i < 150);
      rx_steady = (i < 150);
      if (i == 300) hold_rx = 1'b1;
      if (i == 450) drain_results();
      send_query(random_query());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/sri_pkg.sv
src/sri_in_if.sv
src/sri_out_if.sv
src/sri_front.sv
src/sri_mul.sv
src/sri_cmp.sv
src/segment_rectangle_intersect.sv
test/segment_rectangle_intersect_tb.sv
